FILE: rtl/qpdr_pkg.sv
`default_nettype none
package qpdr_pkg;
  localparam int CAPACITY_DEF = 1024;
  localparam int CLIENTS_DEF = 32;
  localparam int CELL_SIZE_DEF = 16;
  localparam int COORD_W = 16;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_TICK = 3'd2;
  localparam logic [2:0] OP_READ = 3'd3;
  localparam logic [2:0] OP_CLRDIRTY = 3'd4;

  localparam logic [2:0] ST_NONE = 3'd0;
  localparam logic [2:0] ST_ADDED = 3'd1;
  localparam logic [2:0] ST_DUP = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;

  localparam logic [1:0] HS_IDLE = 2'd0;
  localparam logic [1:0] HS_ATTACHED = 2'd2;

  localparam logic [1:0] CMD_NONE = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        do_clear;
    logic        clr_dirty;
    logic        set_dirty;
    logic [2:0]  status;
    logic [15:0] read_index;
    logic [47:0] launch;
    logic [47:0] anchor;
  } qpdr_cmd_t;

  function automatic logic signed [15:0] cell_of(input logic signed [15:0] c,
                                                 input int cs);
    logic signed [15:0] q;
    begin
      q = c / 16'(cs);
      return q;
    end
  endfunction
endpackage
`default_nettype wire

FILE: rtl/qpdr_front.sv
`default_nettype none
module qpdr_front #(
  parameter int CLIENTS = qpdr_pkg::CLIENTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        recording_enabled,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [4:0]  in_client_slot,
  input  wire logic [1:0]  in_hook_state,
  input  wire logic        in_hook_present,
  input  wire logic        in_is_bot,
  input  wire logic [47:0] in_player,
  input  wire logic [47:0] in_anchor,
  input  wire logic [9:0]  in_read_index,
  output logic             q_valid,
  input  wire logic        q_ready,
  output qpdr_pkg::qpdr_cmd_t q_cmd
);
  localparam int SW = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
  logic [CLIENTS-1:0] lvalid_r, noted_r;
  logic [47:0] lpos_r [CLIENTS];
  logic [SW-1:0] sl;
  logic slot_ok;
  qpdr_pkg::qpdr_cmd_t c;

  assign in_ready = q_ready;
  assign q_valid = in_valid;
  assign q_cmd = c;
  assign sl = SW'(in_client_slot);
  assign slot_ok = 32'(in_client_slot) < CLIENTS;

  always_comb begin
    c = '0;
    c.read_index = 16'(in_read_index);
    c.launch = in_player;
    c.anchor = in_anchor;
    unique case (in_opcode)
      qpdr_pkg::OP_CLEAR: c.do_clear = 1'b1;
      qpdr_pkg::OP_LOAD: c.cmd = qpdr_pkg::CMD_INSERT;
      qpdr_pkg::OP_READ: c.cmd = qpdr_pkg::CMD_READ;
      qpdr_pkg::OP_CLRDIRTY: c.clr_dirty = 1'b1;
      qpdr_pkg::OP_TICK: begin
        if (!recording_enabled || in_is_bot || !slot_ok) begin
          c.status = qpdr_pkg::ST_IGNORED;
        end else if (in_hook_state == qpdr_pkg::HS_ATTACHED && in_hook_present
                     && !noted_r[sl]) begin
          c.cmd = qpdr_pkg::CMD_INSERT;
          c.set_dirty = 1'b1;
          c.launch = lvalid_r[sl] ? lpos_r[sl] : in_player;
        end
      end
      default: c.cmd = qpdr_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvalid_r <= '0;
      noted_r <= '0;
    end else if (in_valid && q_ready) begin
      if (in_opcode == qpdr_pkg::OP_CLEAR) begin
        lvalid_r <= '0;
        noted_r <= '0;
      end else if (in_opcode == qpdr_pkg::OP_TICK && recording_enabled &&
                   !in_is_bot && slot_ok) begin
        if (in_hook_state == qpdr_pkg::HS_IDLE) begin
          lvalid_r[sl] <= 1'b0;
          noted_r[sl] <= 1'b0;
        end else begin
          lvalid_r[sl] <= 1'b1;
          if (in_hook_state == qpdr_pkg::HS_ATTACHED && in_hook_present)
            noted_r[sl] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && q_ready && in_opcode == qpdr_pkg::OP_TICK && slot_ok &&
        !lvalid_r[sl] && in_hook_state != qpdr_pkg::HS_IDLE)
      lpos_r[sl] <= in_player;
  end
endmodule
`default_nettype wire

FILE: rtl/qpdr_queue.sv
`default_nettype none
module qpdr_queue (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic w_valid,
  output logic      w_ready,
  input  wire qpdr_pkg::qpdr_cmd_t w_data,
  output logic      r_valid,
  input  wire logic r_ready,
  output qpdr_pkg::qpdr_cmd_t r_data
);
  qpdr_pkg::qpdr_cmd_t mem_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r;
  logic wr, rd;

  assign w_ready = cnt_r != 2'd2;
  assign r_valid = cnt_r != 2'd0;
  assign r_data = mem_r[rp_r];
  assign wr = w_valid && w_ready;
  assign rd = r_valid && r_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= w_data;
  end
endmodule
`default_nettype wire

FILE: rtl/qpdr_back.sv
`default_nettype none
module qpdr_back #(
  parameter int CAPACITY = qpdr_pkg::CAPACITY_DEF,
  parameter int CELL_SIZE = qpdr_pkg::CELL_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        c_valid,
  output logic             c_ready,
  input  wire qpdr_pkg::qpdr_cmd_t c_cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [10:0]      out_entry_total,
  output logic             out_dirty_flag,
  output logic [47:0]      out_launch,
  output logic [47:0]      out_anchor
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_CMP = 3'd2,
                         S_RD = 3'd3, S_OUT = 3'd4;

  logic [47:0] cell_m [CAPACITY];
  logic [47:0] launch_m [CAPACITY];
  logic [47:0] anchor_m [CAPACITY];

  logic [2:0] st_r;
  logic [CW-1:0] cnt_r, idx_r;
  logic dirty_r;
  qpdr_pkg::qpdr_cmd_t cur_r;
  logic [47:0] key_r, crd_r, lrd_r, ard_r;
  logic [2:0] stat_r;
  logic rdv_r, wr;
  logic [AW-1:0] raddr;

  assign c_ready = st_r == S_IDLE && (!out_valid || out_ready);
  assign out_status = stat_r;
  assign out_entry_total = 11'(cnt_r);
  assign out_dirty_flag = dirty_r;
  assign out_launch = rdv_r ? lrd_r : '0;
  assign out_anchor = rdv_r ? ard_r : '0;
  assign raddr = (st_r == S_IDLE) ? AW'(c_cmd.read_index) : AW'(idx_r);
  assign wr = st_r == S_SCAN && idx_r >= cnt_r && cnt_r < CW'(CAPACITY);

  always_ff @(posedge clk) begin
    crd_r <= cell_m[raddr];
    if (st_r == S_IDLE && c_valid && c_ready) begin
      lrd_r <= launch_m[raddr];
      ard_r <= anchor_m[raddr];
    end
    if (wr) begin
      cell_m[AW'(cnt_r)] <= key_r;
      launch_m[AW'(cnt_r)] <= cur_r.launch;
      anchor_m[AW'(cnt_r)] <= cur_r.anchor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      dirty_r <= 1'b0;
      out_valid <= 1'b0;
      rdv_r <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (st_r)
        S_IDLE: if (c_valid && c_ready) begin
          cur_r <= c_cmd;
          stat_r <= c_cmd.status;
          rdv_r <= 1'b0;
          idx_r <= '0;
          key_r <= {qpdr_pkg::cell_of(c_cmd.anchor[47:32], CELL_SIZE),
                    qpdr_pkg::cell_of(c_cmd.anchor[31:16], CELL_SIZE),
                    qpdr_pkg::cell_of(c_cmd.anchor[15:0], CELL_SIZE)};
          if (c_cmd.do_clear) begin
            cnt_r <= '0;
            dirty_r <= 1'b0;
          end
          if (c_cmd.clr_dirty) dirty_r <= 1'b0;
          unique case (c_cmd.cmd)
            qpdr_pkg::CMD_INSERT: st_r <= S_SCAN;
            qpdr_pkg::CMD_READ: st_r <= S_RD;
            default: out_valid <= 1'b1;
          endcase
        end
        S_SCAN: begin
          if (idx_r >= cnt_r) begin
            if (cnt_r >= CW'(CAPACITY)) begin
              stat_r <= qpdr_pkg::ST_FULL;
            end else begin
              stat_r <= qpdr_pkg::ST_ADDED;
              cnt_r <= cnt_r + CW'(1);
              if (cur_r.set_dirty) dirty_r <= 1'b1;
            end
            st_r <= S_OUT;
          end else begin
            st_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (crd_r == key_r) begin
            stat_r <= qpdr_pkg::ST_DUP;
            st_r <= S_OUT;
          end else begin
            idx_r <= idx_r + CW'(1);
            st_r <= S_SCAN;
          end
        end
        S_RD: begin
          rdv_r <= cur_r.read_index < 16'(cnt_r);
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/quantized_point_dedup_recorder_unit.sv
// Quantized point dedup recorder.
// Input channel in_valid/in_ready carries one command transaction: clear,
// load entry, client tick, read entry or clear dirty. Each transaction yields
// exactly one result transaction on out_valid/out_ready with status, entry
// total, dirty flag and, for a read, the stored launch and anchor.
// cfg_valid/cfg_ready writes recording_enabled; write only while idle.
// A front stage tracks per-client hook state and classifies the command; a
// two-entry queue feeds the back stage that owns the point table.
// An insert compares the new cell key against the stored entries one at a
// time over the table memory, so its duration grows with the number of
// stored entries. The back stage takes no new command until its result
// has been taken by the receiver.
// Reset clears the entry count, dirty flag, client tracking and the
// register; table contents need no clearing. A stalled receiver holds the
// result; the queue then fills and in_ready drops.
`default_nettype none
module quantized_point_dedup_recorder_unit #(
  parameter int CAPACITY = qpdr_pkg::CAPACITY_DEF,
  parameter int CLIENTS = qpdr_pkg::CLIENTS_DEF,
  parameter int CELL_SIZE = qpdr_pkg::CELL_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_recording_enabled,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [4:0]  in_client_slot,
  input  wire logic [1:0]  in_hook_state,
  input  wire logic        in_hook_present,
  input  wire logic        in_is_bot,
  input  wire logic signed [15:0] in_player_x,
  input  wire logic signed [15:0] in_player_y,
  input  wire logic signed [15:0] in_player_z,
  input  wire logic signed [15:0] in_anchor_x,
  input  wire logic signed [15:0] in_anchor_y,
  input  wire logic signed [15:0] in_anchor_z,
  input  wire logic [9:0]  in_read_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [10:0]      out_entry_total,
  output logic             out_dirty_flag,
  output logic signed [15:0] out_launch_x,
  output logic signed [15:0] out_launch_y,
  output logic signed [15:0] out_launch_z,
  output logic signed [15:0] out_anchor_x,
  output logic signed [15:0] out_anchor_y,
  output logic signed [15:0] out_anchor_z
);
  logic rec_r;
  logic fq_valid, fq_ready, qb_valid, qb_ready;
  qpdr_pkg::qpdr_cmd_t fq_cmd, qb_cmd;
  logic [47:0] ol, oa;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) rec_r <= 1'b0;
    else if (cfg_valid) rec_r <= cfg_recording_enabled;
  end

  qpdr_front #(.CLIENTS(CLIENTS)) u_front (
    .clk, .rst_n, .recording_enabled(rec_r), .in_valid, .in_ready,
    .in_opcode, .in_client_slot, .in_hook_state, .in_hook_present, .in_is_bot,
    .in_player({in_player_x, in_player_y, in_player_z}),
    .in_anchor({in_anchor_x, in_anchor_y, in_anchor_z}),
    .in_read_index, .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
  );

  qpdr_queue u_queue (
    .clk, .rst_n, .w_valid(fq_valid), .w_ready(fq_ready), .w_data(fq_cmd),
    .r_valid(qb_valid), .r_ready(qb_ready), .r_data(qb_cmd)
  );

  qpdr_back #(.CAPACITY(CAPACITY), .CELL_SIZE(CELL_SIZE)) u_back (
    .clk, .rst_n, .c_valid(qb_valid), .c_ready(qb_ready), .c_cmd(qb_cmd),
    .out_valid, .out_ready, .out_status, .out_entry_total, .out_dirty_flag,
    .out_launch(ol), .out_anchor(oa)
  );

  assign {out_launch_x, out_launch_y, out_launch_z} = ol;
  assign {out_anchor_x, out_anchor_y, out_anchor_z} = oa;
endmodule
`default_nettype wire
